// ===== sv/scem_pkg.sv =====
// ----------------------------------------------------------------------------
// scem_pkg
// Shared types, widths, codes and helpers for the shunt current EMA
// overcurrent monitor.
// ----------------------------------------------------------------------------
package scem_pkg;

  // Converter code width; the sign bit is CODE_BITS-1 (range 16 to 32)
  localparam int CODE_BITS = 24;

  // Payload widths
  localparam int RAW_W    = 24;
  localparam int STATUS_W = 8;
  localparam int CUR_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int ALPHA_W  = 9;
  localparam int CNT_W    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier: operand A holds a code, a sample or a filtered current,
  // operand B a gain or an EMA weight
  localparam int MUL_A_W = (CODE_BITS > CUR_W) ? CODE_BITS : CUR_W;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;

  // Fixed-point constants
  localparam int SCALE_SHIFT = 16;
  localparam int EMA_SHIFT   = 8;
  localparam int ALPHA_ONE   = 1 << EMA_SHIFT;
  localparam int Q24_MAX     = 8388607;
  localparam int Q24_MIN     = -8388608;

  localparam logic signed [ACC_W-1:0] SCALE_ROUND = ACC_W'(1 << (SCALE_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] EMA_ROUND   = ACC_W'(1 << (EMA_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ACC_Q24_MAX = ACC_W'(Q24_MAX);
  localparam logic signed [ACC_W-1:0] ACC_Q24_MIN = ACC_W'(Q24_MIN);

  // Register reset values
  localparam logic [GAIN_W-1:0]       GAIN_RST   = GAIN_W'(5359);
  localparam logic [ALPHA_W-1:0]      ALPHA_RST  = ALPHA_W'(179);
  localparam logic signed [CUR_W-1:0] DIS_RST    = CUR_W'(-100000);
  localparam logic signed [CUR_W-1:0] CHG_RST    = CUR_W'(100000);
  localparam logic [CNT_W-1:0]        RESP_RST   = CNT_W'(3);
  localparam logic [CNT_W-1:0]        RETRY_RST  = CNT_W'(3);
  localparam logic [CNT_W-1:0]        STREAK_MAX = '1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN      = 3'd0,
    REG_ALPHA     = 3'd1,
    REG_DISCHARGE = 3'd2,
    REG_CHARGE    = 3'd3,
    REG_RESPONSE  = 3'd4,
    REG_RETRIES   = 3'd5
  } reg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_COMMS     = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_t;

  // Live configuration, alpha already clamped to one
  typedef struct packed {
    logic [GAIN_W-1:0]       gain;
    logic [ALPHA_W-1:0]      alpha;
    logic signed [CUR_W-1:0] discharge_limit;
    logic signed [CUR_W-1:0] charge_limit;
    logic [CNT_W-1:0]        response_loops;
    logic [CNT_W-1:0]        max_retries;
  } cfg_t;

  // Multiplier control: load starts a new sum from the addend,
  // accumulate adds the product to the held sum
  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctrl_t;

  // Saturate a wide signed value to 24 bits signed
  function automatic logic signed [CUR_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [CUR_W-1:0] r;
    if (v > ACC_Q24_MAX) begin
      r = CUR_W'(Q24_MAX);
    end else if (v < ACC_Q24_MIN) begin
      r = CUR_W'(Q24_MIN);
    end else begin
      r = v[CUR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/scem_if.sv =====
// ----------------------------------------------------------------------------
// scem_if
// Valid/ready channels for converter reads and monitor results.
// ----------------------------------------------------------------------------

// Converter read channel
interface scem_in_if;
  logic                           valid;
  logic                           ready;
  logic                           link_ok;
  logic [scem_pkg::STATUS_W-1:0]  status_byte;
  logic [scem_pkg::RAW_W-1:0]     raw_code;

  modport source (output valid, link_ok, status_byte, raw_code, input ready);
  modport sink   (input valid, link_ok, status_byte, raw_code, output ready);
endinterface

// Monitor result channel
interface scem_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        result_status;
  logic signed [scem_pkg::CUR_W-1:0] current_ma;
  logic                              overcurrent_fault;
  logic                              comms_loss;

  modport source (output valid, result_status, current_ma, overcurrent_fault, comms_loss,
                  input ready);
  modport sink   (input valid, result_status, current_ma, overcurrent_fault, comms_loss,
                  output ready);
endinterface

// ===== sv/scem_cfg.sv =====
// ----------------------------------------------------------------------------
// scem_cfg
// Configuration register file: decodes writes, takes the window limits
// as signed and clamps the EMA weight.
// ----------------------------------------------------------------------------
module scem_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [scem_pkg::CFG_IDX_W-1:0]     index,
  input  logic [scem_pkg::CFG_DATA_W-1:0]    wdata,
  output scem_pkg::cfg_t                     cfg
);
  import scem_pkg::*;

  logic [GAIN_W-1:0]       gain;
  logic [ALPHA_W-1:0]      alpha;
  logic signed [CUR_W-1:0] discharge_limit;
  logic signed [CUR_W-1:0] charge_limit;
  logic [CNT_W-1:0]        response_loops;
  logic [CNT_W-1:0]        max_retries;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RST;
      alpha           <= ALPHA_RST;
      discharge_limit <= DIS_RST;
      charge_limit    <= CHG_RST;
      response_loops  <= RESP_RST;
      max_retries     <= RETRY_RST;
    end else if (we) begin
      case (reg_idx_t'(index))
        REG_GAIN:      gain            <= wdata[GAIN_W-1:0];
        REG_ALPHA:     alpha           <= wdata[ALPHA_W-1:0];
        REG_DISCHARGE: discharge_limit <= $signed(wdata[CUR_W-1:0]);
        REG_CHARGE:    charge_limit    <= $signed(wdata[CUR_W-1:0]);
        REG_RESPONSE:  response_loops  <= wdata[CNT_W-1:0];
        REG_RETRIES:   max_retries     <= wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight above one counts as one
  always_comb begin
    cfg.gain            = gain;
    cfg.alpha           = (alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha;
    cfg.discharge_limit = discharge_limit;
    cfg.charge_limit    = charge_limit;
    cfg.response_loops  = response_loops;
    cfg.max_retries     = max_retries;
  end

endmodule

// ===== sv/scem_mac.sv =====
// ----------------------------------------------------------------------------
// scem_mac
// Shared signed multiply-accumulate unit with a registered sum. Used for the
// gain scaling and for both terms of the EMA update.
// ----------------------------------------------------------------------------
module scem_mac (
  input  logic                                   clk,
  input  scem_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [scem_pkg::MUL_A_W-1:0]    op_a,
  input  logic signed [scem_pkg::MUL_B_W-1:0]    op_b,
  input  logic signed [scem_pkg::ACC_W-1:0]      addend,
  output logic signed [scem_pkg::ACC_W-1:0]      acc
);
  import scem_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] base;

  // One multiply plus one add per cycle while the unit is enabled
  always_comb begin
    prod = ACC_W'(op_a * op_b);
    base = ctrl.accum ? acc : addend;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= base + prod;
    end
  end

endmodule

// ===== sv/shunt_current_ema_overcurrent_monitor.sv =====
// ----------------------------------------------------------------------------
// shunt_current_ema_overcurrent_monitor
// Converter read checker, gain scaling, EMA filter and debounced current
// window check, built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A read whose bus transaction failed, or whose status byte lacks the data
// ready bit, goes straight to S_DONE for its result. A ready read runs
// through the shared multiplier: one pass for the gain scaling and two
// passes for the EMA terms, then the window check and S_DONE (the first
// ready sample skips the EMA passes, as it only seeds the filter); the
// next read is taken once the result is loaded and the state is idle again.
// One result is produced per read; the output register holds it while the
// sink stalls and the next read is already taken. Configuration writes are
// expected only while no read is in flight.
// ----------------------------------------------------------------------------
module shunt_current_ema_overcurrent_monitor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [scem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scem_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  scem_in_if.sink                            in_ch,
  scem_out_if.source                         out_ch
);
  import scem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SAMPLE,
    S_EMA_NEW,
    S_EMA_OLD,
    S_UPDATE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                   state;
  cfg_t                     cfg;
  mac_ctrl_t                mac_ctrl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_addend;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_scaled;
  logic signed [ACC_W-1:0]   acc_ema;

  logic [31:0]              raw_ext;
  logic [CODE_BITS-1:0]     code;
  logic signed [CUR_W-1:0]  sample;
  logic signed [CUR_W-1:0]  filtered;
  logic                     seeded;
  logic [CNT_W-1:0]         oc_streak;
  logic [CNT_W-1:0]         retry_streak;
  status_t                  status;
  logic                     in_accept;
  logic                     out_free;
  logic                     out_of_window;

  scem_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  scem_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .addend (mac_addend),
    .acc    (acc)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign raw_ext     = {{(32 - RAW_W){1'b0}}, in_ch.raw_code};

  // Rounded sums shifted back to their scale (arithmetic shift floors)
  assign acc_scaled    = acc >>> SCALE_SHIFT;
  assign acc_ema       = acc >>> EMA_SHIFT;
  assign out_of_window = (filtered < cfg.discharge_limit) || (filtered > cfg.charge_limit);

  // Operand selection for the shared unit
  always_comb begin
    mac_ctrl   = '0;
    mac_a      = '0;
    mac_b      = '0;
    mac_addend = '0;
    case (state)
      S_SCALE: begin
        mac_ctrl.en = 1'b1;
        mac_a       = MUL_A_W'($signed(code));
        mac_b       = $signed({1'b0, cfg.gain});
        mac_addend  = SCALE_ROUND;
      end
      S_EMA_NEW: begin
        mac_ctrl.en = 1'b1;
        mac_a       = MUL_A_W'(sample);
        mac_b       = $signed(MUL_B_W'(cfg.alpha));
        mac_addend  = EMA_ROUND;
      end
      S_EMA_OLD: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.accum = 1'b1;
        mac_a          = MUL_A_W'(filtered);
        mac_b          = $signed(MUL_B_W'(ALPHA_ONE) - MUL_B_W'(cfg.alpha));
      end
      default: ;
    endcase
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state                    <= S_IDLE;
      seeded                   <= 1'b0;
      filtered                 <= '0;
      oc_streak                <= '0;
      retry_streak             <= '0;
      status                   <= STAT_OK;
      out_ch.valid             <= 1'b0;
    end else begin
      // the load in S_DONE takes over when a new result replaces the old one
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (!in_ch.link_ok) begin
              if (retry_streak != STREAK_MAX) begin
                retry_streak <= retry_streak + 1'b1;
              end
              status <= STAT_COMMS;
              state  <= S_DONE;
            end else begin
              retry_streak <= '0;
              if (!in_ch.status_byte[0]) begin
                status <= STAT_NOT_READY;
                state  <= S_DONE;
              end else begin
                code   <= raw_ext[CODE_BITS-1:0];
                status <= STAT_OK;
                state  <= S_SCALE;
              end
            end
          end
        end
        S_SCALE: state <= S_SAMPLE;
        S_SAMPLE: begin
          sample <= sat24(acc_scaled);
          if (!seeded) begin
            filtered <= sat24(acc_scaled);
            seeded   <= 1'b1;
            state    <= S_CHECK;
          end else begin
            state <= S_EMA_NEW;
          end
        end
        S_EMA_NEW: state <= S_EMA_OLD;
        S_EMA_OLD: state <= S_UPDATE;
        S_UPDATE: begin
          filtered <= sat24(acc_ema);
          state    <= S_CHECK;
        end
        S_CHECK: begin
          if (out_of_window) begin
            if (oc_streak != STREAK_MAX) begin
              oc_streak <= oc_streak + 1'b1;
            end
          end else begin
            oc_streak <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid             <= 1'b1;
            out_ch.result_status     <= status;
            out_ch.current_ma        <= filtered;
            out_ch.overcurrent_fault <= (oc_streak > cfg.response_loops);
            out_ch.comms_loss        <= (retry_streak > cfg.max_retries);
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A taken read keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ch.ready)
    else $error("input ready right after a taken read");

  // Failed-read streak holds at its ceiling
  a_retry_saturates: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !in_ch.link_ok && retry_streak == STREAK_MAX)
      |=> (retry_streak == STREAK_MAX))
    else $error("retry streak wrapped");

  // Overcurrent streak moves only in the window check
  a_streak_only_in_check: assert property (@(posedge clk) disable iff (rst)
    (state != S_CHECK) |=> $stable(oc_streak))
    else $error("overcurrent streak changed outside window check");

  // The EMA update runs only on a seeded filter
  a_update_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> seeded)
    else $error("EMA update on unseeded filter");
`endif

endmodule
